// ----- src/gtht_pkg.sv -----
`timescale 1ns / 1ps

package gtht_pkg;

  // Identifier layout and field widths
  localparam int IDX_FIELD_BITS = 12;
  localparam int ID_GEN_BITS    = 16;
  localparam int ID_BITS        = IDX_FIELD_BITS + ID_GEN_BITS;
  localparam int TYPE_BITS      = 4;
  localparam int FD_BITS        = 31;

  // Parameter defaults
  localparam int DEF_NUM_SLOTS  = 256;
  localparam int DEF_EPOCH_BITS = 16;
  localparam int DEF_REF_BITS   = 16;

  // Scan width of the free-slot search
  localparam int SCAN_LANES = 8;

  typedef enum logic [2:0] {
    FN_ALLOC  = 3'd0,
    FN_ATTACH = 3'd1,
    FN_ABORT  = 3'd2,
    FN_ACQ    = 3'd3,
    FN_REL    = 3'd4,
    FN_CLOSE  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_INVALID   = 3'd1,
    RS_NOT_FOUND = 3'd2,
    RS_ALREADY   = 3'd3,
    RS_BUSY      = 3'd4,
    RS_NO_SPACE  = 3'd5
  } status_e;

  // Request class seen at the input
  typedef enum logic [1:0] {
    DEC_ALLOC,
    DEC_LOOKUP,
    DEC_EARLY
  } dec_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic no_space;
    logic exec;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    dec_e dec;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- src/generation_tagged_handle_table.sv -----
`timescale 1ns / 1ps

// Generational handle table: hands out 28-bit handles (16-bit generation over a
// 12-bit slot index, slot 0 reserved) and runs attach, abort open, acquire,
// release and close on them.
// Input channel s_axis: one word per operation; tuser carries the function code,
// tdata the handle, type, file number and the deps flag.
// Output channel m_axis: exactly one result word per accepted operation, in order;
// tuser carries the status and the fd-valid flag, tdata the new id, type and fd.
// A lookup passes through a memory read and an execute step before its result
// is ready; a rejected request skips both; alloc first runs the free-slot
// search, which walks the used bitmap eight slots per cycle from the
// round-robin pointer (a full table answers without the read and execute steps).
// One operation is in flight at a time; the next word is accepted once the result
// has moved into the output register, which holds while m_axis_tready is low.
// A stalled receiver blocks the table only after that output register is full.
// After reset the entry memory is cleared entry by entry, during which
// s_axis_tready stays low.
module generation_tagged_handle_table #(
  parameter int NUM_SLOTS  = gtht_pkg::DEF_NUM_SLOTS,
  parameter int EPOCH_BITS = gtht_pkg::DEF_EPOCH_BITS,
  parameter int REF_BITS   = gtht_pkg::DEF_REF_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // func
  input  logic [63:0] s_axis_tdata,   // handle, handle_type, host_fd, deps_present
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [3:0]  m_axis_tuser,   // status, fd_valid
  output logic [63:0] m_axis_tdata    // new_id, entry_type, entry_fd, zero pad
);

  gtht_pkg::ctl_cmd_t cmd;
  gtht_pkg::ctl_sts_t sts;

  gtht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gtht_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .EPOCH_BITS (EPOCH_BITS),
    .REF_BITS   (REF_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_func_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- src/gtht_ctrl.sv -----
`timescale 1ns / 1ps

module gtht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gtht_pkg::ctl_sts_t  sts_i,
  output gtht_pkg::ctl_cmd_t  cmd_o
);

  gtht_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtht_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gtht_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = gtht_pkg::S_IDLE;
      end
      gtht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          case (sts_i.dec)
            gtht_pkg::DEC_ALLOC: begin
              cmd_o.scan_start = 1'b1;
              state_d = gtht_pkg::S_SCAN;
            end
            gtht_pkg::DEC_LOOKUP: state_d = gtht_pkg::S_READ;
            default:              state_d = gtht_pkg::S_DONE;
          endcase
        end
      end
      gtht_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = gtht_pkg::S_READ;
        end else if (sts_i.scan_end) begin
          cmd_o.no_space = 1'b1;
          state_d = gtht_pkg::S_DONE;
        end
      end
      gtht_pkg::S_READ: state_d = gtht_pkg::S_EXEC;
      gtht_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = gtht_pkg::S_DONE;
      end
      gtht_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = gtht_pkg::S_IDLE;
        end
      end
      default: state_d = gtht_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- src/gtht_dp.sv -----
`timescale 1ns / 1ps

module gtht_dp #(
  parameter int NUM_SLOTS  = gtht_pkg::DEF_NUM_SLOTS,
  parameter int EPOCH_BITS = gtht_pkg::DEF_EPOCH_BITS,
  parameter int REF_BITS   = gtht_pkg::DEF_REF_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         in_func_i,
  input  logic [63:0]        in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_user_o,
  output logic [63:0]        out_data_o,
  input  gtht_pkg::ctl_cmd_t cmd_i,
  output gtht_pkg::ctl_sts_t sts_o
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LANES  = (NUM_SLOTS < gtht_pkg::SCAN_LANES) ? NUM_SLOTS
                                                             : gtht_pkg::SCAN_LANES;
  localparam int EXT_W  = (EPOCH_BITS > gtht_pkg::ID_GEN_BITS) ? EPOCH_BITS
                                                               : gtht_pkg::ID_GEN_BITS;

  typedef struct packed {
    logic                          ready;
    logic [gtht_pkg::TYPE_BITS-1:0] kind;
    logic                          fvalid;
    logic [gtht_pkg::FD_BITS-1:0]  file;
    logic [REF_BITS-1:0]           refs;
    logic [EPOCH_BITS-1:0]         epoch;
  } entry_t;

  // Input fields
  logic [gtht_pkg::ID_BITS-1:0]        in_id;
  logic [gtht_pkg::TYPE_BITS-1:0]      in_type;
  logic [gtht_pkg::FD_BITS-1:0]        in_fd;
  logic                                in_deps;
  logic [gtht_pkg::IDX_FIELD_BITS-1:0] in_idx;
  logic                                idx_bad;
  gtht_pkg::status_e                   early_st;
  gtht_pkg::dec_e                      dec_sel;

  assign in_id   = in_data_i[27:0];
  assign in_type = in_data_i[31:28];
  assign in_fd   = in_data_i[62:32];
  assign in_deps = in_data_i[63];
  assign in_idx  = in_id[gtht_pkg::IDX_FIELD_BITS-1:0];
  assign idx_bad = (in_idx == '0) ||
                   ({1'b0, in_idx} >= (gtht_pkg::IDX_FIELD_BITS+1)'(NUM_SLOTS));

  // Classify the incoming word
  always_comb begin
    dec_sel  = gtht_pkg::DEC_EARLY;
    early_st = gtht_pkg::RS_INVALID;
    case (in_func_i)
      gtht_pkg::FN_ALLOC: begin
        if (in_type != '0) dec_sel = gtht_pkg::DEC_ALLOC;
      end
      gtht_pkg::FN_ATTACH, gtht_pkg::FN_ABORT, gtht_pkg::FN_ACQ, gtht_pkg::FN_REL: begin
        if (idx_bad) early_st = gtht_pkg::RS_NOT_FOUND;
        else dec_sel = gtht_pkg::DEC_LOOKUP;
      end
      gtht_pkg::FN_CLOSE: begin
        if (in_deps) early_st = gtht_pkg::RS_BUSY;
        else if (idx_bad) early_st = gtht_pkg::RS_NOT_FOUND;
        else dec_sel = gtht_pkg::DEC_LOOKUP;
      end
      default: early_st = gtht_pkg::RS_INVALID;
    endcase
  end

  assign sts_o.dec = dec_sel;

  // Request registers
  logic [2:0]                        func_q;
  logic [gtht_pkg::ID_GEN_BITS-1:0]  gen_q;
  logic [gtht_pkg::TYPE_BITS-1:0]    type_q;
  logic [gtht_pkg::FD_BITS-1:0]      fd_q;
  logic [SLOT_W-1:0]                 slot_q;

  // Table state
  entry_t                 mem_q [NUM_SLOTS];
  entry_t                 rd_q;
  logic [NUM_SLOTS-1:0]   used_q;
  logic [SLOT_W-1:0]      start_q;
  logic [SLOT_W-1:0]      clr_cnt_q;
  logic [SLOT_W:0]        ptr_q;
  logic [SLOT_W:0]        rem_q;

  // Free-slot scan over a few lanes per cycle
  logic [SLOT_W:0]   pos [LANES];
  logic [SLOT_W:0]   ptr_next;
  logic              hit;
  logic [SLOT_W-1:0] pick;
  always_comb begin
    hit  = 1'b0;
    pick = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      pos[k] = ptr_q + (SLOT_W+1)'(k);
      if (pos[k] >= (SLOT_W+1)'(NUM_SLOTS)) pos[k] = pos[k] - (SLOT_W+1)'(NUM_SLOTS);
      if (((SLOT_W+1)'(k) < rem_q) && (pos[k] != '0) && !used_q[pos[k][SLOT_W-1:0]]) begin
        hit  = 1'b1;
        pick = pos[k][SLOT_W-1:0];
      end
    end
    ptr_next = ptr_q + (SLOT_W+1)'(LANES);
    if (ptr_next >= (SLOT_W+1)'(NUM_SLOTS)) ptr_next = ptr_next - (SLOT_W+1)'(NUM_SLOTS);
  end

  assign sts_o.scan_hit = hit;
  assign sts_o.scan_end = rem_q <= (SLOT_W+1)'(LANES);
  assign sts_o.clr_last = clr_cnt_q == SLOT_W'(NUM_SLOTS - 1);

  // Execute one operation on the entry read back
  logic [EXT_W-1:0]                  ep_old_x, ep_new_x;
  logic [EPOCH_BITS-1:0]             ep_new;
  logic                              found;
  logic                              we, set_used, clr_used;
  entry_t                            wdata;
  logic [SLOT_W-1:0]                 waddr;
  gtht_pkg::status_e                 x_st;
  logic [gtht_pkg::ID_BITS-1:0]      x_id;
  logic [gtht_pkg::TYPE_BITS-1:0]    x_type;
  logic [gtht_pkg::FD_BITS-1:0]      x_fd;
  logic                              x_fv;
  entry_t                            freed;

  assign ep_new   = rd_q.epoch + 1'b1;
  assign ep_old_x = EXT_W'(rd_q.epoch);
  assign ep_new_x = EXT_W'(ep_new);
  assign found    = used_q[slot_q] && (ep_old_x[gtht_pkg::ID_GEN_BITS-1:0] == gen_q);

  always_comb begin
    freed       = '0;
    freed.file  = rd_q.file;
    freed.epoch = rd_q.epoch;
    we       = 1'b0;
    set_used = 1'b0;
    clr_used = 1'b0;
    wdata    = rd_q;
    waddr    = slot_q;
    x_st     = gtht_pkg::RS_OK;
    x_id     = '0;
    x_type   = '0;
    x_fd     = '0;
    x_fv     = 1'b0;
    case (func_q)
      gtht_pkg::FN_ALLOC: begin
        we       = 1'b1;
        set_used = 1'b1;
        wdata       = freed;
        wdata.kind  = type_q;
        wdata.epoch = ep_new;
        x_id = {ep_new_x[gtht_pkg::ID_GEN_BITS-1:0], (gtht_pkg::IDX_FIELD_BITS)'(slot_q)};
      end
      gtht_pkg::FN_ATTACH: begin
        if (!found) x_st = gtht_pkg::RS_NOT_FOUND;
        else if (rd_q.ready) x_st = gtht_pkg::RS_ALREADY;
        else begin
          we = 1'b1;
          wdata.file   = fd_q;
          wdata.fvalid = 1'b1;
          wdata.ready  = 1'b1;
        end
      end
      gtht_pkg::FN_ABORT: begin
        if (!found) x_st = gtht_pkg::RS_NOT_FOUND;
        else if (rd_q.ready) x_st = gtht_pkg::RS_ALREADY;
        else begin
          we = 1'b1;
          clr_used = 1'b1;
          wdata = freed;
          x_fv  = rd_q.fvalid;
          x_fd  = rd_q.fvalid ? rd_q.file : '0;
        end
      end
      gtht_pkg::FN_ACQ: begin
        if (!found) x_st = gtht_pkg::RS_NOT_FOUND;
        else if (!rd_q.ready || (rd_q.refs == '1)) x_st = gtht_pkg::RS_BUSY;
        else begin
          we = 1'b1;
          wdata.refs = rd_q.refs + 1'b1;
          x_type = rd_q.kind;
          x_fv   = rd_q.fvalid;
          x_fd   = rd_q.fvalid ? rd_q.file : '0;
        end
      end
      gtht_pkg::FN_REL: begin
        if (!found) x_st = gtht_pkg::RS_NOT_FOUND;
        else if (rd_q.refs == '0) x_st = gtht_pkg::RS_INVALID;
        else begin
          we = 1'b1;
          wdata.refs = rd_q.refs - 1'b1;
        end
      end
      gtht_pkg::FN_CLOSE: begin
        if (!found) x_st = gtht_pkg::RS_NOT_FOUND;
        else if (rd_q.refs != '0) begin
          we = 1'b1;
          wdata.ready = 1'b0;
          x_st = gtht_pkg::RS_BUSY;
        end else begin
          we = 1'b1;
          clr_used = 1'b1;
          wdata = freed;
          x_fv  = rd_q.fvalid;
          x_fd  = rd_q.fvalid ? rd_q.file : '0;
        end
      end
      default: x_st = gtht_pkg::RS_INVALID;
    endcase
    we = we & cmd_i.exec;
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end
  end

  // Entry memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[slot_q];
  end

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q <= in_func_i;
      gen_q  <= in_id[gtht_pkg::ID_BITS-1:gtht_pkg::IDX_FIELD_BITS];
      type_q <= in_type;
      fd_q   <= in_fd;
      slot_q <= in_idx[SLOT_W-1:0];
    end else if (cmd_i.scan_step && hit) begin
      slot_q <= pick;
    end
  end

  // Result held until the output register frees up
  gtht_pkg::status_e               res_st_q;
  logic [gtht_pkg::ID_BITS-1:0]    res_id_q;
  logic [gtht_pkg::TYPE_BITS-1:0]  res_type_q;
  logic [gtht_pkg::FD_BITS-1:0]    res_fd_q;
  logic                            res_fv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      res_st_q   <= early_st;
      res_id_q   <= '0;
      res_type_q <= '0;
      res_fd_q   <= '0;
      res_fv_q   <= 1'b0;
    end else if (cmd_i.no_space) begin
      res_st_q <= gtht_pkg::RS_NO_SPACE;
    end else if (cmd_i.exec) begin
      res_st_q   <= x_st;
      res_id_q   <= x_id;
      res_type_q <= x_type;
      res_fd_q   <= x_fd;
      res_fv_q   <= x_fv;
    end
  end

  // Control state: bitmap, pointers, clear counter, output valid
  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      start_q   <= SLOT_W'(1);
      clr_cnt_q <= '0;
      ptr_q     <= '0;
      rem_q     <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.scan_start) begin
        ptr_q <= {1'b0, start_q};
        rem_q <= (SLOT_W+1)'(NUM_SLOTS);
      end else if (cmd_i.scan_step) begin
        ptr_q <= ptr_next;
        rem_q <= rem_q - (SLOT_W+1)'(LANES);
      end
      if (cmd_i.exec && set_used) begin
        used_q[slot_q] <= 1'b1;
        start_q <= (slot_q == SLOT_W'(NUM_SLOTS - 1)) ? SLOT_W'(1) : slot_q + 1'b1;
      end
      if (cmd_i.exec && clr_used) used_q[slot_q] <= 1'b0;
      if (cmd_i.out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // Output register
  logic [3:0]  out_user_q;
  logic [63:0] out_data_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_user_q <= {res_fv_q, res_st_q};
      out_data_q <= {1'b0, res_fd_q, res_type_q, res_id_q};
    end
  end

  assign sts_o.out_free = !out_v_q || out_ready_i;
  assign out_valid_o    = out_v_q;
  assign out_user_o     = out_user_q;
  assign out_data_o     = out_data_q;

  // Checks
  a_slot0_free: assert property (@(posedge clk_i) disable iff (!rst_ni) !used_q[0])
    else $error("reserved slot marked used");
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && set_used) |-> !used_q[slot_q])
    else $error("alloc picked a used slot");
  a_start_nz: assert property (@(posedge clk_i) disable iff (!rst_ni) start_q != '0)
    else $error("search pointer on reserved slot");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(cmd_i.out_load))
    else $error("output valid without a result load");

endmodule

// ----- verif/generation_tagged_handle_table_test.sv -----
`timescale 1ns / 1ps

module generation_tagged_handle_table_test;

  localparam int NSLOT   = gtht_pkg::DEF_NUM_SLOTS;
  localparam int REF_MAX = (1 << gtht_pkg::DEF_REF_BITS) - 1;
  localparam int EP_MASK = (1 << gtht_pkg::DEF_EPOCH_BITS) - 1;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [27:0] new_id;
    logic [3:0]  etype;
    logic [30:0] efd;
    logic        fval;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [3:0]  m_axis_tuser;
  logic [63:0] m_axis_tdata;

  generation_tagged_handle_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
  );

  // Shadow table state
  bit          tb_used [NSLOT];
  bit          tb_ready[NSLOT];
  logic [3:0]  tb_kind [NSLOT];
  logic [30:0] tb_file [NSLOT];
  bit          tb_fval [NSLOT];
  int unsigned tb_refs [NSLOT];
  int unsigned tb_epoch[NSLOT];
  int unsigned next_free;

  outcome_t    pending_results[$];
  int          errors = 0;
  int          results_seen = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  longint      cycles = 0;
  logic [27:0] live_ids[$];

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_slot(int s);
    tb_used[s] = 0; tb_ready[s] = 0; tb_kind[s] = '0;
    tb_file[s] = '0; tb_fval[s] = 0; tb_refs[s] = 0;
  endfunction

  // Return slot on hit, 0 on miss
  function automatic int find_slot(logic [27:0] id);
    int s;
    s = id[11:0];
    if (s == 0 || s >= NSLOT) return 0;
    if (!tb_used[s] || tb_epoch[s][15:0] != id[27:12]) return 0;
    return s;
  endfunction

  function automatic outcome_t table_outcome(logic [2:0] fn, logic [27:0] id,
                                             logic [3:0] ty, logic [30:0] fd, bit deps);
    outcome_t r;
    int s;
    int k;
    r = '0;
    r.status = gtht_pkg::RS_INVALID;
    case (fn)
      gtht_pkg::FN_ALLOC: begin
        if (ty != 0) begin
          r.status = gtht_pkg::RS_NO_SPACE;
          for (k = 0; k < NSLOT; k++) begin
            s = (next_free + k) % NSLOT;
            if (s == 0 || tb_used[s]) continue;
            tb_epoch[s] = (tb_epoch[s] + 1) & EP_MASK;
            clear_slot(s);
            tb_used[s] = 1;
            tb_kind[s] = ty;
            r.new_id = {tb_epoch[s][15:0], 12'(s)};
            next_free = (s + 1) % NSLOT;
            if (next_free == 0) next_free = 1;
            r.status = gtht_pkg::RS_OK;
            live_ids.push_back(r.new_id);
            break;
          end
        end
      end
      gtht_pkg::FN_ATTACH: begin
        s = find_slot(id);
        if (s == 0) r.status = gtht_pkg::RS_NOT_FOUND;
        else if (tb_ready[s]) r.status = gtht_pkg::RS_ALREADY;
        else begin
          tb_file[s] = fd; tb_fval[s] = 1; tb_ready[s] = 1;
          r.status = gtht_pkg::RS_OK;
        end
      end
      gtht_pkg::FN_ABORT: begin
        s = find_slot(id);
        if (s == 0) r.status = gtht_pkg::RS_NOT_FOUND;
        else if (tb_ready[s]) r.status = gtht_pkg::RS_ALREADY;
        else begin
          if (tb_fval[s]) begin r.efd = tb_file[s]; r.fval = 1; end
          clear_slot(s);
          r.status = gtht_pkg::RS_OK;
        end
      end
      gtht_pkg::FN_ACQ: begin
        s = find_slot(id);
        if (s == 0) r.status = gtht_pkg::RS_NOT_FOUND;
        else if (!tb_ready[s] || tb_refs[s] >= REF_MAX) r.status = gtht_pkg::RS_BUSY;
        else begin
          tb_refs[s]++;
          r.etype = tb_kind[s];
          if (tb_fval[s]) begin r.efd = tb_file[s]; r.fval = 1; end
          r.status = gtht_pkg::RS_OK;
        end
      end
      gtht_pkg::FN_REL: begin
        s = find_slot(id);
        if (s == 0) r.status = gtht_pkg::RS_NOT_FOUND;
        else if (tb_refs[s] == 0) r.status = gtht_pkg::RS_INVALID;
        else begin
          tb_refs[s]--;
          r.status = gtht_pkg::RS_OK;
        end
      end
      gtht_pkg::FN_CLOSE: begin
        if (deps) r.status = gtht_pkg::RS_BUSY;
        else begin
          s = find_slot(id);
          if (s == 0) r.status = gtht_pkg::RS_NOT_FOUND;
          else begin
            tb_ready[s] = 0;
            if (tb_refs[s] != 0) r.status = gtht_pkg::RS_BUSY;
            else begin
              if (tb_fval[s]) begin r.efd = tb_file[s]; r.fval = 1; end
              clear_slot(s);
              r.status = gtht_pkg::RS_OK;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one word and queue its predicted result; valid stays up for a following word
  task automatic send_op(logic [2:0] fn, logic [27:0] id, logic [3:0] ty,
                         logic [30:0] fd, bit deps);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pending_results.push_back(table_outcome(fn, id, ty, fd, deps));
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {deps, fd, ty, id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with no prediction pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[2:0] !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser[2:0]);
          errors++;
        end
        if (m_axis_tuser[3] !== want.fval) begin
          $error("fd_valid: expected %0d actual %0d", want.fval, m_axis_tuser[3]);
          errors++;
        end
        if (m_axis_tdata[27:0] !== want.new_id) begin
          $error("new_id: expected %h actual %h", want.new_id, m_axis_tdata[27:0]);
          errors++;
        end
        if (m_axis_tdata[31:28] !== want.etype) begin
          $error("entry_type: expected %0d actual %0d", want.etype, m_axis_tdata[31:28]);
          errors++;
        end
        if (m_axis_tdata[62:32] !== want.efd) begin
          $error("entry_fd: expected %h actual %h", want.efd, m_axis_tdata[62:32]);
          errors++;
        end
      end
    end
  end

  function automatic logic [27:0] pick_id();
    logic [27:0] id;
    int k;
    if (live_ids.size() != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(live_ids.size() - 1);
      id = live_ids[k];
      if ($urandom_range(19) == 0) id[27:12] = id[27:12] + 1;
      return id;
    end
    return 28'($urandom);
  endfunction

  function automatic logic [30:0] rand_fd();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [27:0] h;
    send_op(3'd6, 28'h0, 4'h1, '0, 0);
    send_op(3'd7, '1, '1, '1, 1);
    send_op(gtht_pkg::FN_ALLOC, '0, 4'h0, '0, 0);
    send_op(gtht_pkg::FN_ATTACH, '0, '0, '1, 0);
    send_op(gtht_pkg::FN_ACQ, 28'hFFFFFFF, '0, '0, 0);
    send_op(gtht_pkg::FN_ALLOC, '0, 4'hF, '0, 0);
    h = {16'd1, 12'd1};
    send_op(gtht_pkg::FN_ACQ, h, '0, '0, 0);
    send_op(gtht_pkg::FN_ATTACH, h, '0, 31'h7FFFFFFF, 0);
    send_op(gtht_pkg::FN_ATTACH, h, '0, 31'h1, 0);
    send_op(gtht_pkg::FN_ABORT, h, '0, '0, 0);
    send_op(gtht_pkg::FN_REL, h, '0, '0, 0);
    send_op(gtht_pkg::FN_ACQ, h, '0, '0, 0);
    send_op(gtht_pkg::FN_ACQ, {16'd2, 12'd1}, '0, '0, 0);
    send_op(gtht_pkg::FN_CLOSE, h, '0, '0, 1);
    send_op(gtht_pkg::FN_CLOSE, h, '0, '0, 0);
    send_op(gtht_pkg::FN_ATTACH, h, '0, 31'h0, 0);
    send_op(gtht_pkg::FN_REL, h, '0, '0, 0);
    send_op(gtht_pkg::FN_CLOSE, h, '0, '0, 0);
    send_op(gtht_pkg::FN_CLOSE, h, '0, '0, 0);
    send_op(gtht_pkg::FN_ALLOC, '0, 4'h1, '0, 0);
    send_op(gtht_pkg::FN_ABORT, {16'd1, 12'd2}, '0, '0, 0);
    send_op(gtht_pkg::FN_CLOSE, {16'd0, 12'hFFF}, '0, '0, 0);
  endtask

  // Fill the table until it reports no space, then free everything
  task automatic test_exhaustion();
    logic [27:0] h;
    for (int k = 0; k < NSLOT + 1; k++)
      send_op(gtht_pkg::FN_ALLOC, '0, 4'($urandom_range(15, 1)), '0, 0);
    drain_results();
    while (live_ids.size() != 0) begin
      h = live_ids.pop_front();
      send_op(gtht_pkg::FN_ABORT, h, '0, '0, 0);
    end
  endtask

  task automatic test_random(int n_ops);
    logic [2:0] fn;
    int r;
    for (int k = 0; k < n_ops; k++) begin
      r = $urandom_range(99);
      if (live_ids.size() < 4 || r < 15) fn = gtht_pkg::FN_ALLOC;
      else if (r < 30) fn = gtht_pkg::FN_ATTACH;
      else if (r < 50) fn = gtht_pkg::FN_ACQ;
      else if (r < 65) fn = gtht_pkg::FN_REL;
      else if (r < 72) fn = gtht_pkg::FN_ABORT;
      else if (r < 93) fn = gtht_pkg::FN_CLOSE;
      else fn = 3'($urandom);
      send_op(fn, pick_id(), 4'($urandom), rand_fd(), $urandom_range(7) == 0);
      if (live_ids.size() > 40) void'(live_ids.pop_front());
    end
  endtask

  initial begin
    int n_run;
    for (int s = 0; s < NSLOT; s++) begin
      clear_slot(s);
      tb_epoch[s] = 0;
    end
    next_free = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 27; recv_idle_pct = 73;
    test_directed();
    drain_results();
    test_exhaustion();
    n_run = 270;
    test_random(n_run);
    send_idle_pct = 73; recv_idle_pct = 27;
    test_random(n_run);
    // hold off until the table has answered everything
    drain_results();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(n_run);

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Covered directed edge cases, table exhaustion and %0d result words", results_seen);
    $display("under three sender/receiver idling mixes.");
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
